[design/sot_pkg.sv]
// Shared constants, types and codes for the spherical orientation test.
// No dependencies; every file but sot_fifo imports this package.
package sot_pkg;

  localparam int ANG_FRAC   = 16;
  localparam int RES_FRAC   = 46;
  localparam int UNIT_BITS  = 30;
  localparam int N_TERMS    = 6;
  localparam int OUT_DEPTH  = 64;

  localparam logic [54:0] RAD_PER_DEG_Q60 = 55'd20122276272436452;
  localparam logic [20:0] TOL_RESET       = 21'd70;
  localparam logic [46:0] AREA_MAX        = {47{1'b1}};

  localparam int IN_W  = 152;
  localparam int OUT_W = 56;

  typedef enum logic [1:0] {
    TURN_COLL = 2'd0,
    TURN_CCW  = 2'd1,
    TURN_CW   = 2'd2
  } turn_t;

  typedef struct packed {
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic [29:0]        x2;
    logic signed [31:0] s;
    logic signed [31:0] c;
    logic               swap;
    logic [1:0]         quad;
  } kern_t;

endpackage

[design/sot_cell.sv]
// One series cell: next sine and cosine Taylor terms and running sums.
// Depends on sot_pkg.
module sot_cell
  import sot_pkg::*;
#(
  parameter int IDX = 1
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  src_vld,
  input  kern_t src_k,
  output logic  dst_vld,
  output kern_t dst_k
);

  localparam int DS = (2 * IDX) * (2 * IDX + 1);
  localparam int DC = (2 * IDX - 1) * (2 * IDX);
  localparam int KS = 31 + $clog2(DS);
  localparam int KC = 31 + $clog2(DC);
  localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);
  localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);
  localparam bit SUB = (IDX % 2) == 1;

  logic        vld1, vld2;
  logic [60:0] ps, pc;
  kern_t       k1, k2;
  logic [64:0] ms, mc;
  logic [31:0] ns, nc;
  logic [30:0] ts_new, tc_new;

  always_comb begin
    ns = 32'((ps + (61'd1 << 29)) >> 30) + 32'(DS / 2);
    nc = 32'((pc + (61'd1 << 29)) >> 30) + 32'(DC / 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= src_vld;
      vld2 <= vld1;
    end
    ps <= 61'(src_k.ts) * 61'(src_k.x2);
    pc <= 61'(src_k.tc) * 61'(src_k.x2);
    k1 <= src_k;
    ms <= 65'(ns) * 65'(MS[32:0]);
    mc <= 65'(nc) * 65'(MC[32:0]);
    k2 <= k1;
  end

  always_comb begin
    ts_new  = 31'(ms >> KS);
    tc_new  = 31'(mc >> KC);
    dst_k   = k2;
    dst_k.ts = ts_new;
    dst_k.tc = tc_new;
    if (SUB) begin
      dst_k.s = k2.s - $signed({1'b0, ts_new});
      dst_k.c = k2.c - $signed({1'b0, tc_new});
    end else begin
      dst_k.s = k2.s + $signed({1'b0, ts_new});
      dst_k.c = k2.c + $signed({1'b0, tc_new});
    end
    dst_vld = vld2;
  end

endmodule

[design/sot_sincos.sv]
// Sine and cosine of a fixed-point angle in degrees, Q30 results.
// Depends on sot_pkg and sot_cell.
module sot_sincos
  import sot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic signed [24:0] angle,
  output logic               out_vld,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  localparam int QUARTER = 90 << ANG_FRAC;
  localparam int FULL    = 4 * QUARTER;
  localparam int HALF    = QUARTER / 2;
  localparam logic [26:0] RH = RAD_PER_DEG_Q60[54:28];
  localparam logic [27:0] RL = RAD_PER_DEG_Q60[27:0];

  logic [5:0]  vld;
  logic [24:0] r1;
  logic [22:0] f2;
  logic [1:0]  q2, q3, q4, q5, q6;
  logic [21:0] g3;
  logic        sw3, sw4, sw5, sw6;
  logic [48:0] ph;
  logic [49:0] pl;
  logic [29:0] x5, x6;
  logic [59:0] xx6;
  logic signed [25:0] wrap;
  logic [77:0] xsum;

  kern_t kc [0:N_TERMS];
  logic  kv [0:N_TERMS];

  always_comb begin
    wrap = 26'(angle) + 26'(FULL);
    xsum = (78'(ph) << 28) + 78'(pl) + (78'd1 << 45);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_vld};
    end
    r1 <= angle[24] ? 25'(wrap) : 25'(angle);
    if (r1 >= 25'(3 * QUARTER)) begin
      q2 <= 2'd3;
      f2 <= 23'(r1 - 25'(3 * QUARTER));
    end else if (r1 >= 25'(2 * QUARTER)) begin
      q2 <= 2'd2;
      f2 <= 23'(r1 - 25'(2 * QUARTER));
    end else if (r1 >= 25'(QUARTER)) begin
      q2 <= 2'd1;
      f2 <= 23'(r1 - 25'(QUARTER));
    end else begin
      q2 <= 2'd0;
      f2 <= 23'(r1);
    end
    if (f2 > 23'(HALF)) begin
      g3  <= 22'(23'(QUARTER) - f2);
      sw3 <= 1'b1;
    end else begin
      g3  <= 22'(f2);
      sw3 <= 1'b0;
    end
    q3  <= q2;
    ph  <= 49'(g3) * 49'(RH);
    pl  <= 50'(g3) * 50'(RL);
    q4  <= q3;
    sw4 <= sw3;
    x5  <= 30'(xsum >> 46);
    q5  <= q4;
    sw5 <= sw4;
    xx6 <= 60'(x5) * 60'(x5);
    x6  <= x5;
    q6  <= q5;
    sw6 <= sw5;
  end

  always_comb begin
    kc[0].ts   = 31'(x6);
    kc[0].tc   = 31'd1 << UNIT_BITS;
    kc[0].x2   = 30'((xx6 + (60'd1 << 29)) >> 30);
    kc[0].s    = 32'(x6);
    kc[0].c    = 32'd1 << UNIT_BITS;
    kc[0].swap = sw6;
    kc[0].quad = q6;
    kv[0]      = vld[5];
  end

  for (genvar i = 1; i <= N_TERMS; i++) begin : g_cell
    sot_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .src_vld (kv[i-1]),
      .src_k   (kc[i-1]),
      .dst_vld (kv[i]),
      .dst_k   (kc[i])
    );
  end

  logic signed [31:0] sc, cc, s0, c0;

  always_comb begin
    if (kc[N_TERMS].s < 0) sc = '0;
    else if (kc[N_TERMS].s > (32'sd1 <<< UNIT_BITS)) sc = 32'sd1 <<< UNIT_BITS;
    else sc = kc[N_TERMS].s;
    if (kc[N_TERMS].c < 0) cc = '0;
    else if (kc[N_TERMS].c > (32'sd1 <<< UNIT_BITS)) cc = 32'sd1 <<< UNIT_BITS;
    else cc = kc[N_TERMS].c;
    s0 = kc[N_TERMS].swap ? cc : sc;
    c0 = kc[N_TERMS].swap ? sc : cc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= kv[N_TERMS];
    end
    unique case (kc[N_TERMS].quad)
      2'd0: begin sn <= s0;  cs <= c0;  end
      2'd1: begin sn <= c0;  cs <= -s0; end
      2'd2: begin sn <= -s0; cs <= -c0; end
      default: begin sn <= -c0; cs <= s0; end
    endcase
  end

endmodule

[design/sot_fifo.sv]
// Result queue with a registered output stage.
// No dependencies; stands alone.
module sot_fifo #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count, count_next;
  logic             pop;

  always_comb begin
    pop        = (count != '0) && (!out_valid || out_ready);
    count_next = count + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (pop) out_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[design/spherical_orientation_test_top.sv]
// Top level: six angle units, unit vectors, triple product, tolerance and queue.
// Depends on sot_pkg, sot_sincos, sot_cell and sot_fifo.
//
//  channel   dir  signals                              carries
//  s_axis    in   s_axis_tvalid/tready/tdata[151:0]    request of three points
//  m_axis    out  m_axis_tvalid/tready/tdata[55:0]     turn and signed area
//  cfg       in   cfg_valid/ready/data[20:0]           collinear tolerance
//
// One request per cycle sustained while s_axis_tready stays high; a result passes
// through 19 register stages in the angle units, 11 in the vector products and
// rounding, and two in the queue.
// Reset clears valid bits, credit and the queue; tolerance returns to 70.
// Stalls on m_axis fill the queue; s_axis drops tready once OUT_DEPTH
// requests are in flight.
module spherical_orientation_test_top
  import sot_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // p_lat[23:0] p_lon[48:24] q_lat[72:49] q_lon[97:73] r_lat[121:98] r_lon[146:122]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // turn[1:0] signed_area[49:2]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [20:0]       cfg_data
);

  localparam int SHIFT = 3 * UNIT_BITS - RES_FRAC;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [20:0]   tol;
  logic [CW-1:0] credit;
  logic          in_acc, out_acc;

  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = credit < CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= TOL_RESET;
      credit <= '0;
    end else begin
      if (cfg_valid) tol <= cfg_data;
      credit <= credit + CW'(in_acc) - CW'(out_acc);
    end
  end

  logic signed [24:0] ang [6];
  logic signed [31:0] sn [6];
  logic signed [31:0] cs [6];
  logic               sv [6];

  always_comb begin
    ang[0] = 25'($signed(s_axis_tdata[23:0]));
    ang[1] = $signed(s_axis_tdata[48:24]);
    ang[2] = 25'($signed(s_axis_tdata[72:49]));
    ang[3] = $signed(s_axis_tdata[97:73]);
    ang[4] = 25'($signed(s_axis_tdata[121:98]));
    ang[5] = $signed(s_axis_tdata[146:122]);
  end

  for (genvar i = 0; i < 6; i++) begin : g_ang
    sot_sincos u_sincos (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (in_acc),
      .angle   (ang[i]),
      .out_vld (sv[i]),
      .sn      (sn[i]),
      .cs      (cs[i])
    );
  end

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [33:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = 34'((m + (64'd1 << 29)) >> 30);
    return v[63] ? -$signed(32'(r)) : $signed(32'(r));
  endfunction

  logic [9:0] vld;
  logic signed [63:0] prx [3], pry [3];
  logic signed [31:0] z1 [3];
  logic signed [31:0] vx [3], vy [3], vz [3];
  logic signed [63:0] a0, a1, b0, b1, c0, c1;
  logic signed [31:0] p1 [3], p2 [3];
  logic signed [63:0] n [3];
  logic signed [63:0] lo [3];
  logic signed [64:0] hi [3];
  logic signed [95:0] t [3];
  logic signed [95:0] sa, t2d, acc;
  logic               neg1, neg2;
  logic [94:0]        mag1;
  logic [46:0]        mag2;
  logic [94:0]        sh;
  turn_t              turn;
  logic [47:0]        area;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[8:0], sv[0]};
    end
    for (int k = 0; k < 3; k++) begin
      prx[k] <= 64'(cs[2*k]) * 64'(cs[2*k+1]);
      pry[k] <= 64'(cs[2*k]) * 64'(sn[2*k+1]);
      z1[k]  <= sn[2*k];
      vx[k]  <= rnd30(prx[k]);
      vy[k]  <= rnd30(pry[k]);
      vz[k]  <= z1[k];
    end
    a0 <= 64'(vy[1]) * 64'(vz[2]);
    a1 <= 64'(vz[1]) * 64'(vy[2]);
    b0 <= 64'(vz[1]) * 64'(vx[2]);
    b1 <= 64'(vx[1]) * 64'(vz[2]);
    c0 <= 64'(vx[1]) * 64'(vy[2]);
    c1 <= 64'(vy[1]) * 64'(vx[2]);
    p1[0] <= vx[0];
    p1[1] <= vy[0];
    p1[2] <= vz[0];
    n[0] <= a0 - a1;
    n[1] <= b0 - b1;
    n[2] <= c0 - c1;
    for (int k = 0; k < 3; k++) begin
      p2[k] <= p1[k];
      lo[k] <= 64'($signed({1'b0, n[k][30:0]})) * 64'(p2[k]);
      hi[k] <= 65'($signed(n[k][63:31])) * 65'(p2[k]);
      t[k]  <= (96'(hi[k]) <<< 31) + 96'(lo[k]);
    end
    sa   <= t[0] + t[1];
    t2d  <= t[2];
    acc  <= sa + t2d;
    neg1 <= acc[95];
    mag1 <= 95'(acc[95] ? -acc : acc);
    neg2 <= neg1;
    mag2 <= (sh > 95'(AREA_MAX)) ? AREA_MAX : sh[46:0];
  end

  always_comb begin
    sh = (mag1 + (95'd1 << (SHIFT - 1))) >> SHIFT;
    priority if (48'(mag2) < 48'(tol)) turn = TURN_COLL;
    else if (!neg2 && mag2 != '0) turn = TURN_CCW;
    else turn = TURN_CW;
    area = neg2 ? 48'(-{1'b0, mag2}) : {1'b0, mag2};
  end

  logic [OUT_W-1:0] res;
  logic             res_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= vld[9];
    end
    res <= {6'd0, area, turn};
  end

  sot_fifo #(.DEPTH(DEPTH), .WIDTH(OUT_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_vld),
    .push_data (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

[bench/sot_checker.sv]
`timescale 1ns / 1ps
// Checker for the spherical orientation test: watches the request, result and
// tolerance channels, predicts each result and compares it. Depends on sot_pkg.
module sot_checker
  import sot_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [20:0]      cfg_data,
  output int               errors,
  output int               pending
);

  typedef struct {
    turn_t              turn;
    logic signed [47:0] area;
  } orient_t;

  orient_t     awaited[$];
  logic [20:0] tolerance;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic void series(input longint unsigned g, output longint sn,
                                 output longint cs);
    logic [127:0]    prod;
    longint unsigned x, x2, ts, tc, ds, dc;
    prod = 128'(g) * 128'(RAD_PER_DEG_Q60);
    x = 64'((prod + (128'd1 << 45)) >> 46);
    x2 = q30_mul(x, x);
    ts = x;
    tc = 64'd1 << 30;
    sn = longint'(x);
    cs = longint'(tc);
    for (int i = 1; i <= 6; i++) begin
      ds = 64'(2 * i) * 64'(2 * i + 1);
      dc = 64'(2 * i - 1) * 64'(2 * i);
      ts = (q30_mul(ts, x2) + ds / 2) / ds;
      tc = (q30_mul(tc, x2) + dc / 2) / dc;
      if (i % 2 == 1) begin
        sn -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        sn += longint'(ts);
        cs += longint'(tc);
      end
    end
    if (sn < 0) sn = 0;
    if (sn > (64'sd1 << 30)) sn = 64'sd1 << 30;
    if (cs < 0) cs = 0;
    if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
  endfunction

  function automatic void sin_cos(input longint a, output longint sn, output longint cs);
    longint quarter, full, r, q, f, s0, c0;
    quarter = 64'sd90 << ANG_FRAC;
    full = quarter * 4;
    r = a % full;
    if (r < 0) r += full;
    q = r / quarter;
    f = r - q * quarter;
    if (f > quarter / 2) series(quarter - f, c0, s0);
    else series(f, s0, c0);
    case (q)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  function automatic longint q30_round(longint v);
    longint half;
    half = 64'sd1 << 29;
    if (v < 0) return -((-v + half) >>> 30);
    return (v + half) >>> 30;
  endfunction

  function automatic void on_sphere(input longint lat, input longint lon,
                                    output longint v[3]);
    longint sl, cl, so, co;
    sin_cos(lat, sl, cl);
    sin_cos(lon, so, co);
    v[0] = q30_round(cl * co);
    v[1] = q30_round(cl * so);
    v[2] = sl;
  endfunction

  function automatic orient_t orientation(logic [IN_W-1:0] d, logic [20:0] tol);
    longint             p[3], q[3], r[3], n[3];
    logic signed [127:0] acc, nw, pw;
    logic [127:0]        mag;
    logic                neg;
    orient_t             o;
    on_sphere(longint'($signed(d[23:0])), longint'($signed(d[48:24])), p);
    on_sphere(longint'($signed(d[72:49])), longint'($signed(d[97:73])), q);
    on_sphere(longint'($signed(d[121:98])), longint'($signed(d[146:122])), r);
    n[0] = q[1] * r[2] - q[2] * r[1];
    n[1] = q[2] * r[0] - q[0] * r[2];
    n[2] = q[0] * r[1] - q[1] * r[0];
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      nw = n[i];
      pw = p[i];
      acc += nw * pw;
    end
    neg = acc < 0;
    mag = neg ? -acc : acc;
    mag = (mag + (128'd1 << 43)) >> 44;
    if (mag > 128'(AREA_MAX)) mag = 128'(AREA_MAX);
    o.area = neg ? -$signed(48'(mag)) : $signed(48'(mag));
    if (mag < 128'(tol)) o.turn = TURN_COLL;
    else if (!neg && mag > 0) o.turn = TURN_CCW;
    else o.turn = TURN_CW;
    return o;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    orient_t o;
    if (rst) begin
      tolerance <= TOL_RESET;
      errors <= 0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) awaited.push_back(orientation(s_axis_tdata, tolerance));
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          o = awaited.pop_front();
          if (m_axis_tdata[1:0] !== o.turn || m_axis_tdata[49:2] !== o.area) begin
            $display("%0t: expected turn %0d area %0d, got turn %0d area %0d", $time,
                     o.turn, o.area, m_axis_tdata[1:0], $signed(m_axis_tdata[49:2]));
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[bench/tb_spherical_orientation_test_top.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the spherical orientation test block.
// Depends on sot_pkg, spherical_orientation_test_top and sot_checker.
module tb_spherical_orientation_test_top;
  import sot_pkg::*;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;
  localparam int IDLE_LIMIT = 20000;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [20:0]      cfg_data = '0;
  int               errors, pending;
  int               idle_cycles = 0;
  int               burst_left = 0;

  always #1 clk = ~clk;

  spherical_orientation_test_top dut (.*);

  sot_checker chk (.*);

  function automatic logic [IN_W-1:0] points(int pa, int po, int qa, int qo, int ra, int ro);
    logic [IN_W-1:0] d;
    d = '0;
    d[23:0] = pa[23:0];
    d[48:24] = po[24:0];
    d[72:49] = qa[23:0];
    d[97:73] = qo[24:0];
    d[121:98] = ra[23:0];
    d[146:122] = ro[24:0];
    return d;
  endfunction

  function automatic int any_lat();
    return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int any_lon();
    return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  function automatic logic [IN_W-1:0] random_points();
    logic [IN_W-1:0] d;
    int k, lon, lat;
    k = $urandom_range(0, 9);
    lon = any_lon();
    lat = any_lat();
    if (k < 6) d = points(any_lat(), any_lon(), any_lat(), any_lon(), any_lat(), any_lon());
    else if (k == 6) begin
      d = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      d[151:147] = '0;
    end else if (k == 7) d = points(any_lat(), lon, any_lat(), lon, any_lat(), lon);
    else if (k == 8) d = points(0, any_lon(), 0, any_lon(), 0, any_lon());
    else d = points(lat, lon, any_lat(), any_lon(), lat + $urandom_range(0, 4) - 2,
                    lon + $urandom_range(0, 4) - 2);
    return d;
  endfunction

  task automatic send(logic [IN_W-1:0] d);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic set_tolerance(logic [20:0] v);
    s_axis_tvalid <= 0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // receiver: alternate between always ready, random stalls and long holds
  always @(posedge clk) begin
    int mode, left;
    if (left == 0) begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 200);
    end
    left--;
    case (mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [20:0] tols[4];
    tols = '{21'd0, 21'd1048576, 21'd2097151, 21'd70};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(points(0, 0, 0, 0, 0, 0));
    send(points(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 0, 0));
    send(points(0, 0, 0, 90 << 16, LAT_MAX, 0));
    send(points(0, 0, 0, 90 << 16, -LAT_MAX, 0));
    send(points(45 << 16, 45 << 16, -(45 << 16), 135 << 16, 30 << 16, -(60 << 16)));
    send(points(10 << 16, LON_MAX, 10 << 16, -LON_MAX, 20 << 16, 0));
    send(points(0, 0, 0, 10 << 16, 0, 20 << 16));
    send(points(10 << 16, 5 << 16, 40 << 16, 5 << 16, -30 << 16, 5 << 16));
    send(points(-8388608, -16777216, 8388607, 16777215, -8388608, 16777215));
    send(points(1, -1, -1, 1, 2, 3));
    send(points(LAT_MAX - 1, 1 << 16, 0, LON_MAX - 1, 200 << 16, 400 << 16));
    send(points(30 << 16, 20 << 16, 30 << 16, 20 << 16, 60 << 16, 70 << 16));
    set_tolerance(21'd0);
    send(points(0, 0, 0, 0, 0, 0));
    send(points(0, 0, 0, 10 << 16, 0, 20 << 16));
    send(points(20 << 16, 0, 20 << 16, 0, 20 << 16, 0));
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 206; i++) send(random_points());
      if (ph < 4) set_tolerance(ph == 3 ? 21'($urandom_range(0, 1048576)) : tols[ph + 1]);
    end
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[spherical_orientation_test_top.f]
design/sot_pkg.sv
design/sot_cell.sv
design/sot_sincos.sv
design/sot_fifo.sv
design/spherical_orientation_test_top.sv
bench/sot_checker.sv
bench/tb_spherical_orientation_test_top.sv
